// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the return address guard.
// Needs nothing else; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property does not hold");
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: hw/rtl/ralg_pkg.sv
// Shared types and constants of the return address guard.
// Used by ralg_cell and return_address_location_guard_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ralg_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int ADDR_W        = 32;
   localparam int THREAD_W      = 3;

   typedef enum logic [1:0] {
      CMD_CALL        = 2'd0,
      CMD_RETURN      = 2'd1,
      CMD_RETURN_PUSH = 2'd2,
      CMD_WRITE       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NOT_FOUND  = 3'd1,
      ST_NOT_LOWEST = 3'd2,
      ST_OVERWRITE  = 3'd3,
      ST_PUSH_DROP  = 3'd4,
      ST_FULL       = 3'd5
   } status_type;

   // thread and location that a scan or an update refers to
   typedef struct packed {
      logic [THREAD_W-1:0] thread;
      logic [ADDR_W-1:0]   addr;
   } key_type;

   // partial result carried along the row of cells
   typedef struct packed {
      logic              match;
      logic              low_valid;
      logic [ADDR_W-1:0] low_addr;
      logic              free_valid;
   } scan_type;

   typedef enum logic [1:0] {
      UPD_NONE     = 2'd0,
      UPD_INSERT   = 2'd1,
      UPD_CLEAR_LE = 2'd2,
      UPD_CLEAR_EQ = 2'd3
   } upd_kind_type;

   typedef struct packed {
      upd_kind_type kind;
      key_type      key;
   } update_type;

endpackage
`default_nettype wire

// File: hw/rtl/ralg_cell.sv
// One slot of the return address table plus its stage of the scan row.
// Depends on ralg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ralg_cell #(
   parameter int SLOTS      = ralg_pkg::SLOTS_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ralg_pkg::key_type          key,
   input  wire logic                       scan_valid_in,
   input  wire ralg_pkg::scan_type         scan_in,
   input  wire logic [$clog2(SLOTS)-1:0]   free_idx_in,
   output logic                            scan_valid_out,
   output ralg_pkg::scan_type              scan_out,
   output logic [$clog2(SLOTS)-1:0]        free_idx_out,
   input  wire ralg_pkg::update_type       update,
   input  wire logic [$clog2(SLOTS)-1:0]   update_idx
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic                          used_ff, used_in;
   logic [ralg_pkg::THREAD_W-1:0] owner_ff, owner_in;
   logic [ralg_pkg::ADDR_W-1:0]   slot_addr_ff, slot_addr_in;

   logic                          scan_valid_ff;
   ralg_pkg::scan_type            scan_ff, scan_in_next;
   logic [IDX_W-1:0]              idx_ff, idx_in;

   logic hit, own;

   // merge this slot into the passing partial result
   always_comb begin
      hit          = used_ff && (owner_ff == key.thread);
      scan_in_next = scan_in;
      idx_in       = free_idx_in;
      if (hit && (slot_addr_ff == key.addr)) begin
         scan_in_next.match = 1'b1;
      end
      if (hit && (!scan_in.low_valid || (slot_addr_ff < scan_in.low_addr))) begin
         scan_in_next.low_valid = 1'b1;
         scan_in_next.low_addr  = slot_addr_ff;
      end
      if (!used_ff && !scan_in.free_valid) begin
         scan_in_next.free_valid = 1'b1;
         idx_in                  = MY_IDX;
      end
   end

   // apply the broadcast update to this slot
   always_comb begin
      own          = used_ff && (owner_ff == update.key.thread);
      used_in      = used_ff;
      owner_in     = owner_ff;
      slot_addr_in = slot_addr_ff;
      case (update.kind)
         ralg_pkg::UPD_INSERT: begin
            if (update_idx == MY_IDX) begin
               used_in      = 1'b1;
               owner_in     = update.key.thread;
               slot_addr_in = update.key.addr;
            end
         end
         ralg_pkg::UPD_CLEAR_LE: begin
            if (own && (slot_addr_ff <= update.key.addr)) begin
               used_in = 1'b0;
            end
         end
         ralg_pkg::UPD_CLEAR_EQ: begin
            if (own && (slot_addr_ff == update.key.addr)) begin
               used_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= 1'b0;
         scan_valid_ff <= 1'b0;
      end else begin
         used_ff       <= used_in;
         scan_valid_ff <= scan_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff     <= owner_in;
      slot_addr_ff <= slot_addr_in;
      scan_ff      <= scan_in_next;
      idx_ff       <= idx_in;
   end

   assign scan_valid_out = scan_valid_ff;
   assign scan_out       = scan_ff;
   assign free_idx_out   = idx_ff;

endmodule
`default_nettype wire

// File: hw/rtl/return_address_location_guard_unit.sv
// Top level of the return address guard: control, result register and cell row.
// Depends on ralg_pkg, ralg_cell and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Return address location guard. Keeps a shared table of SLOTS stack
// locations that hold return addresses, each tagged with its owning
// thread. A call (command 0) adds its stack pointer to the thread's set
// unless present already, into the free slot with the lowest index, and
// reports table full (5) if no slot is free. A return (1) looks up the
// stack pointer: when missing it reports not found (1); when present it
// removes that entry and every lower entry of the thread, reporting
// match not lowest (2) if the hit was not the thread's lowest entry. A
// return after push (2) drops the thread's lowest entry and reports
// push drop (4). A memory write (3) to a stored location of the thread
// reports overwrite (3). Every word also returns the thread's lowest
// stored location before the event (0 when it has none) and whether it
// had any. Each slot lives in a cell of a row; an event sends a scan
// token down the row, one cell per cycle, collecting hit, lowest entry
// and first free slot, and the table is then updated by one broadcast.
// The time from one acceptance to the next is set by the length of the
// cell row, and the finished event waits while the output register still
// holds an untaken result; the result word is registered. A new event is
// accepted while an earlier result still waits to be taken.
// The table is empty right after reset, with no clearing pass.
module return_address_location_guard_unit #(
   parameter int SLOTS = ralg_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [2:0]  req_thread,
   input  wire logic [31:0] req_address,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_lowest_address,
   output logic             rsp_lowest_valid
);

   localparam int IDX_W = $clog2(SLOTS);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic                   start_ff, start_in;
   ralg_pkg::cmd_type      cmd_ff;
   ralg_pkg::key_type      key_ff;
   ralg_pkg::scan_type     fin_ff;
   logic [IDX_W-1:0]       fin_idx_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   ralg_pkg::status_type   rsp_status_ff;
   logic [31:0]            rsp_lowest_address_ff;
   logic                   rsp_lowest_valid_ff;

   logic                   accept, out_free, retire, last_valid;
   ralg_pkg::status_type   dec_status;
   ralg_pkg::update_type   dec_update, update;

   logic                   valid_chain [SLOTS+1];
   ralg_pkg::scan_type     scan_chain  [SLOTS+1];
   logic [IDX_W-1:0]       idx_chain   [SLOTS+1];

   // handshake: take a word only between events
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_valid = valid_chain[SLOTS];
   assign retire     = (state_ff == S_FINISH) && out_free;

   // row of cells; the scan token enters cell 0 in the cycle after acceptance
   assign valid_chain[0] = start_ff;
   assign scan_chain[0]  = '0;
   assign idx_chain[0]   = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ralg_cell #(
         .SLOTS      (SLOTS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .key            (key_ff),
         .scan_valid_in  (valid_chain[g]),
         .scan_in        (scan_chain[g]),
         .free_idx_in    (idx_chain[g]),
         .scan_valid_out (valid_chain[g+1]),
         .scan_out       (scan_chain[g+1]),
         .free_idx_out   (idx_chain[g+1]),
         .update         (update),
         .update_idx     (fin_idx_ff)
      );
   end

   // decide status and table update from the finished scan
   always_comb begin
      dec_status      = ralg_pkg::ST_OK;
      dec_update.kind = ralg_pkg::UPD_NONE;
      dec_update.key  = key_ff;
      unique case (cmd_ff)
         ralg_pkg::CMD_CALL: begin
            if (!fin_ff.match) begin
               if (fin_ff.free_valid) begin
                  dec_update.kind = ralg_pkg::UPD_INSERT;
               end else begin
                  dec_status = ralg_pkg::ST_FULL;
               end
            end
         end
         ralg_pkg::CMD_RETURN: begin
            if (!fin_ff.match) begin
               dec_status = ralg_pkg::ST_NOT_FOUND;
            end else begin
               dec_update.kind = ralg_pkg::UPD_CLEAR_LE;
               // addresses are unique per thread, so compare by value
               if (key_ff.addr != fin_ff.low_addr) begin
                  dec_status = ralg_pkg::ST_NOT_LOWEST;
               end
            end
         end
         ralg_pkg::CMD_RETURN_PUSH: begin
            dec_status = ralg_pkg::ST_PUSH_DROP;
            if (fin_ff.low_valid) begin
               dec_update.kind     = ralg_pkg::UPD_CLEAR_EQ;
               dec_update.key.addr = fin_ff.low_addr;
            end
         end
         ralg_pkg::CMD_WRITE: begin
            if (fin_ff.match) begin
               dec_status = ralg_pkg::ST_OVERWRITE;
            end
         end
         default: begin
         end
      endcase
   end

   // broadcast the update only in the cycle the result word is loaded
   always_comb begin
      update = dec_update;
      if (!retire) begin
         update.kind = ralg_pkg::UPD_NONE;
      end
   end

   // sequencer: idle, scan down the row, wait for the output register
   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               start_in = 1'b1;
            end
         end
         S_SCAN: begin
            if (last_valid) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the event, capture the scan result, load the result word
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= ralg_pkg::cmd_type'(req_command);
         key_ff.thread <= req_thread;
         key_ff.addr   <= req_address;
      end
      if ((state_ff == S_SCAN) && last_valid) begin
         fin_ff     <= scan_chain[SLOTS];
         fin_idx_ff <= idx_chain[SLOTS];
      end
      if (retire) begin
         rsp_status_ff         <= dec_status;
         rsp_lowest_address_ff <= fin_ff.low_addr;
         rsp_lowest_valid_ff   <= fin_ff.low_valid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_lowest_address = rsp_lowest_address_ff;
   assign rsp_lowest_valid   = rsp_lowest_valid_ff;

   `ASSERT_HOLDS(a_scan_end_in_scan, clock, reset, last_valid |-> (state_ff == S_SCAN))
   `ASSERT_HOLDS(a_update_on_retire, clock, reset, (update.kind != ralg_pkg::UPD_NONE) |-> retire)
   `ASSERT_HOLDS(a_insert_needs_free, clock, reset, (update.kind == ralg_pkg::UPD_INSERT) |-> fin_ff.free_valid)
   `ASSERT_HOLDS(a_one_event_at_time, clock, reset, accept |=> (!req_ready && start_ff))
   `ASSERT_HOLDS(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))

endmodule
`default_nettype wire
